// ===== sv/smcd_pkg.sv =====
// ============================================================================
// smcd_pkg
// Shared types, constants and helper functions for the decimating separable
// 2D filter with mirrored borders.
// ============================================================================
package smcd_pkg;

    // Default sizing of the top level
    localparam int DEF_MAX_SIDE  = 256;
    localparam int DEF_MAX_ORDER = 3;
    localparam int DEF_MAX_DOWN  = 4;

    // Field and register widths
    localparam int COORD_W  = 8;
    localparam int SAMPLE_W = 16;
    localparam int TAP_W    = 16;
    localparam int OUT_W    = 32;
    localparam int ORDER_W  = 2;
    localparam int DOWN_W   = 3;
    localparam int OSIDE_W  = 9;
    localparam int TLO_W    = 64;
    localparam int THI_W    = 48;
    localparam int SIZE_W   = OSIDE_W + DOWN_W;   // input side, out side * factor
    localparam int CTR_W    = COORD_W + DOWN_W;   // window center
    localparam int IDX_W    = SIZE_W + 2;         // signed window index
    localparam int TT_W     = 2 * TAP_W;          // tap by tap product
    localparam int PROD_W   = TT_W + SAMPLE_W;    // full term
    localparam int SHIFT    = 28;

    // APB port geometry: 64-bit data, registers at 8-byte steps
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    typedef enum logic [2:0] {
        REG_ORDER     = 3'd0,
        REG_DOWN      = 3'd1,
        REG_OUT_COLS  = 3'd2,
        REG_OUT_ROWS  = 3'd3,
        REG_TAPS_LOW  = 3'd4,
        REG_TAPS_HIGH = 3'd5
    } reg_idx_t;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_COORD = 2'd1,
        STAT_GEOM  = 2'd2
    } status_t;

    typedef struct packed {
        logic                       action;
        logic [COORD_W-1:0]         row;
        logic [COORD_W-1:0]         col;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic [1:0]              status;
    } result_t;

    // Derived input geometry
    typedef struct packed {
        logic              ok;
        logic [SIZE_W-1:0] in_rows;
        logic [SIZE_W-1:0] in_cols;
    } geom_t;

    // One window term handed to the multiply-accumulate pipe
    typedef struct packed {
        logic                    vld;
        logic                    first;
        logic                    last;
        logic signed [TAP_W-1:0] ty;
        logic signed [TAP_W-1:0] tx;
    } mac_issue_t;

    // Pick tap k out of the two tap registers
    function automatic logic signed [TAP_W-1:0] tap_sel(
        input logic [TLO_W-1:0] lo,
        input logic [THI_W-1:0] hi,
        input logic [2:0]       k
    );
        logic [TAP_W-1:0] bits;
        case (k)
            3'd0:    bits = lo[15:0];
            3'd1:    bits = lo[31:16];
            3'd2:    bits = lo[47:32];
            3'd3:    bits = lo[63:48];
            3'd4:    bits = hi[15:0];
            3'd5:    bits = hi[31:16];
            3'd6:    bits = hi[47:32];
            default: bits = '0;
        endcase
        return $signed(bits);
    endfunction

    // Fold a window index back into 0..n-1 (one reflection, n > order)
    function automatic logic [SIZE_W-1:0] mirror_idx(
        input logic signed [IDX_W-1:0] i,
        input logic [SIZE_W-1:0]       n
    );
        logic signed [IDX_W-1:0] a;
        logic signed [IDX_W-1:0] ns;
        ns = $signed(IDX_W'(n));
        a  = i[IDX_W-1] ? -i : i;
        if (a >= ns)
        begin
            a = ns + ns - a - $signed(IDX_W'(2));
        end
        return a[SIZE_W-1:0];
    endfunction

endpackage

// ===== sv/smcd_ram.sv =====
// ============================================================================
// smcd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Contents are undefined until written.
// ============================================================================
module smcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/smcd_geom.sv =====
// ============================================================================
// smcd_geom
// Geometry decoder: derives the input grid size from the output size and the
// decimation factor, and flags any setting the filter cannot run with.
// ============================================================================
module smcd_geom import smcd_pkg::*; #(
    parameter int MAX_SIDE  = DEF_MAX_SIDE,
    parameter int MAX_ORDER = DEF_MAX_ORDER,
    parameter int MAX_DOWN  = DEF_MAX_DOWN
) (
    input  logic [ORDER_W-1:0] order,
    input  logic [DOWN_W-1:0]  down_factor,
    input  logic [OSIDE_W-1:0] out_cols,
    input  logic [OSIDE_W-1:0] out_rows,
    output geom_t              geom
);

    localparam logic [OSIDE_W-1:0] OSIDE_MAX = OSIDE_W'(256);

    logic [SIZE_W-1:0] in_cols;
    logic [SIZE_W-1:0] in_rows;
    logic              bad_order;
    logic              bad_down;
    logic              bad_out;
    logic              bad_side;
    logic              bad_fold;

    // Scale output size up to the input grid
    assign in_cols = SIZE_W'(out_cols) * SIZE_W'(down_factor);
    assign in_rows = SIZE_W'(out_rows) * SIZE_W'(down_factor);

    // Check each limit
    assign bad_order = int'(order) > MAX_ORDER;
    assign bad_down  = (down_factor == '0) || (int'(down_factor) > MAX_DOWN);
    assign bad_out   = (out_cols == '0) || (out_cols > OSIDE_MAX)
                    || (out_rows == '0) || (out_rows > OSIDE_MAX);
    assign bad_side  = (int'(in_cols) > MAX_SIDE) || (int'(in_rows) > MAX_SIDE);
    // A side no larger than the order would need more than one reflection
    assign bad_fold  = (in_cols <= SIZE_W'(order)) || (in_rows <= SIZE_W'(order));

    assign geom.ok      = !(bad_order || bad_down || bad_out || bad_side || bad_fold);
    assign geom.in_rows = in_rows;
    assign geom.in_cols = in_cols;

endmodule

// ===== sv/smcd_mac.sv =====
// ============================================================================
// smcd_mac
// Multiply-accumulate pipe: tap product, times the sample read from the image
// store, summed over the window; then scaled down by 2^28 with floor.
// ============================================================================
module smcd_mac import smcd_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_issue_t              issue,
    input  logic [SAMPLE_W-1:0]     rdata,
    output logic signed [OUT_W-1:0] filtered,
    output logic                    done
);

    localparam int TERMS = (2 * MAX_ORDER + 1) * (2 * MAX_ORDER + 1);
    localparam int ACC_W = PROD_W + $clog2(TERMS);
    localparam int RES_W = ACC_W - SHIFT;

    // Stage 1: taps, aligned with the registered RAM read
    logic                       p1_vld_reg;
    logic                       p1_first_reg;
    logic                       p1_last_reg;
    logic signed [TAP_W-1:0]    p1_ty_reg;
    logic signed [TAP_W-1:0]    p1_tx_reg;
    // Stage 2: tap product and sample
    logic                       p2_vld_reg;
    logic                       p2_first_reg;
    logic                       p2_last_reg;
    logic signed [TT_W-1:0]     p2_tt_reg;
    logic signed [SAMPLE_W-1:0] p2_smp_reg;
    // Stage 3: full term
    logic                       p3_vld_reg;
    logic                       p3_first_reg;
    logic                       p3_last_reg;
    logic signed [PROD_W-1:0]   p3_prod_reg;
    // Accumulator
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       done_reg;

    logic signed [TT_W-1:0]     tt;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    acc_base;
    logic signed [RES_W-1:0]    shifted;

    assign tt       = p1_ty_reg * p1_tx_reg;
    assign prod     = p2_tt_reg * p2_smp_reg;
    assign acc_base = p3_first_reg ? '0 : acc_reg;

    // Advance control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= issue.vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            done_reg   <= p3_vld_reg && p3_last_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        p1_first_reg <= issue.first;
        p1_last_reg  <= issue.last;
        p1_ty_reg    <= issue.ty;
        p1_tx_reg    <= issue.tx;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_tt_reg    <= tt;
        p2_smp_reg   <= $signed(rdata);
        p3_first_reg <= p2_first_reg;
        p3_last_reg  <= p2_last_reg;
        p3_prod_reg  <= prod;
        if (p3_vld_reg)
        begin
            acc_reg <= acc_base + ACC_W'(p3_prod_reg);
        end
    end

    // Floor shift; the window sum is too narrow to leave the 32-bit range
    assign shifted  = acc_reg[ACC_W-1:SHIFT];
    assign filtered = OUT_W'(shifted);
    assign done     = done_reg;

endmodule

// ===== sv/separable_mirror_conv2d_decimate.sv =====
// ============================================================================
// separable_mirror_conv2d_decimate
// Decimating separable 2D filter over an on-chip image store with mirrored
// borders.
// ============================================================================
// Usage:
//   Configure through the APB port (64-bit data, register i at byte 8*i)
//   while the block is idle. Items arrive on item/item_valid/item_stall and
//   results leave on result/result_valid/result_stall; a transfer happens when
//   valid is high and stall is low. Every item gives exactly one result.
//   A write item stores one sample; the block stays idle when the result
//   slot is free. A read item walks the (2*order+1)^2 window, one image store read
//   per cycle, then drains the four-stage multiply-accumulate pipe; the
//   single store read port sets the pace of the walk. Items with a bad
//   coordinate or geometry answer like writes.
//   The block takes a new item while a finished result waits in the output
//   register; if the receiver keeps stalling, one further result is held
//   inside and item_stall stays high until the output drains.
//   Reset clears the configuration to its defaults and empties the pipe; the
//   image store is not cleared and must be written before it is read.
// ============================================================================
module separable_mirror_conv2d_decimate import smcd_pkg::*; #(
    parameter int MAX_SIDE  = DEF_MAX_SIDE,
    parameter int MAX_ORDER = DEF_MAX_ORDER,
    parameter int MAX_DOWN  = DEF_MAX_DOWN
) (
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Items
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    // Results
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result
);

    localparam int SIDE_W = $clog2(MAX_SIDE);
    localparam int ADDR_W = 2 * SIDE_W;
    localparam int K_W    = $clog2(2 * MAX_ORDER + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Configuration registers
    logic [ORDER_W-1:0] order_reg;
    logic [DOWN_W-1:0]  down_reg;
    logic [OSIDE_W-1:0] out_cols_reg;
    logic [OSIDE_W-1:0] out_rows_reg;
    logic [TLO_W-1:0]   taps_low_reg;
    logic [THI_W-1:0]   taps_high_reg;

    // Sequencer
    state_t             state_reg;
    logic [CTR_W-1:0]   cy_reg;
    logic [CTR_W-1:0]   cx_reg;
    logic [K_W-1:0]     ky_reg;
    logic [K_W-1:0]     kx_reg;
    result_t            hold_reg;
    result_t            result_reg;
    logic               result_valid_reg;

    geom_t              geom;
    reg_idx_t           cfg_idx;
    logic               cfg_wr;
    logic               take_item;
    logic               is_read;
    logic               wr_bad;
    logic               rd_bad;
    logic               starts_read;
    logic               slot_free;
    logic               out_load;
    result_t            imm_res;
    logic [2:0]         span;
    logic               kx_end;
    logic               win_last;
    logic signed [IDX_W-1:0] iy;
    logic signed [IDX_W-1:0] ix;
    logic [SIZE_W-1:0]  ry;
    logic [SIZE_W-1:0]  rx;
    mac_issue_t         issue;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic signed [OUT_W-1:0] mac_filtered;
    logic               mac_done;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite;

    // Latch a register on the access cycle of a write transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= '0;
            down_reg      <= DOWN_W'(1);
            out_cols_reg  <= OSIDE_W'(64);
            out_rows_reg  <= OSIDE_W'(64);
            taps_low_reg  <= '0;
            taps_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ORDER:     order_reg     <= pwdata[ORDER_W-1:0];
                REG_DOWN:      down_reg      <= pwdata[DOWN_W-1:0];
                REG_OUT_COLS:  out_cols_reg  <= pwdata[OSIDE_W-1:0];
                REG_OUT_ROWS:  out_rows_reg  <= pwdata[OSIDE_W-1:0];
                REG_TAPS_LOW:  taps_low_reg  <= pwdata[TLO_W-1:0];
                REG_TAPS_HIGH: taps_high_reg <= pwdata[THI_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_ORDER:     prdata = PDATA_W'(order_reg);
            REG_DOWN:      prdata = PDATA_W'(down_reg);
            REG_OUT_COLS:  prdata = PDATA_W'(out_cols_reg);
            REG_OUT_ROWS:  prdata = PDATA_W'(out_rows_reg);
            REG_TAPS_LOW:  prdata = PDATA_W'(taps_low_reg);
            REG_TAPS_HIGH: prdata = PDATA_W'(taps_high_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Geometry
    // ------------------------------------------------------------------
    smcd_geom #(
        .MAX_SIDE  (MAX_SIDE),
        .MAX_ORDER (MAX_ORDER),
        .MAX_DOWN  (MAX_DOWN)
    ) u_geom (
        .order       (order_reg),
        .down_factor (down_reg),
        .out_cols    (out_cols_reg),
        .out_rows    (out_rows_reg),
        .geom        (geom)
    );

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    assign item_stall  = (state_reg != ST_IDLE);
    assign take_item   = item_valid && !item_stall;
    assign is_read     = (item.action == ACT_READ);
    assign wr_bad      = (SIZE_W'(item.row) >= geom.in_rows)
                      || (SIZE_W'(item.col) >= geom.in_cols);
    assign rd_bad      = (OSIDE_W'(item.row) >= out_rows_reg)
                      || (OSIDE_W'(item.col) >= out_cols_reg);
    assign starts_read = is_read && geom.ok && !rd_bad;
    assign slot_free   = !result_valid_reg || !result_stall;

    // Load the output register with an immediate or a finished result
    assign out_load = ((state_reg == ST_IDLE) && take_item && !starts_read && slot_free)
                   || ((state_reg == ST_FINISH) && slot_free);

    // Answer for writes and rejected items
    always_comb
    begin
        imm_res.filtered = '0;
        if (!geom.ok)
        begin
            imm_res.status = STAT_GEOM;
        end
        else if (is_read ? rd_bad : wr_bad)
        begin
            imm_res.status = STAT_COORD;
        end
        else
        begin
            imm_res.status = STAT_OK;
        end
    end

    // Store a sample on an accepted, valid write
    assign ram_we    = take_item && !is_read && geom.ok && !wr_bad;
    assign ram_waddr = {SIDE_W'(item.row), SIDE_W'(item.col)};

    // ------------------------------------------------------------------
    // Window walk: mirrored addresses and taps
    // ------------------------------------------------------------------
    assign span     = {order_reg, 1'b0};
    assign kx_end   = (3'(kx_reg) == span);
    assign win_last = kx_end && (3'(ky_reg) == span);

    assign iy = $signed(IDX_W'(cy_reg)) - $signed(IDX_W'(order_reg))
              + $signed(IDX_W'(ky_reg));
    assign ix = $signed(IDX_W'(cx_reg)) - $signed(IDX_W'(order_reg))
              + $signed(IDX_W'(kx_reg));
    assign ry = mirror_idx(iy, geom.in_rows);
    assign rx = mirror_idx(ix, geom.in_cols);

    assign ram_re    = (state_reg == ST_RUN);
    assign ram_raddr = {ry[SIDE_W-1:0], rx[SIDE_W-1:0]};

    assign issue.vld   = (state_reg == ST_RUN);
    assign issue.first = (ky_reg == '0) && (kx_reg == '0);
    assign issue.last  = win_last;
    assign issue.ty    = tap_sel(taps_low_reg, taps_high_reg, 3'(ky_reg));
    assign issue.tx    = tap_sel(taps_low_reg, taps_high_reg, 3'(kx_reg));

    smcd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SIDE * MAX_SIDE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.sample),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smcd_mac #(
        .MAX_ORDER (MAX_ORDER)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .rdata    (ram_rdata),
        .filtered (mac_filtered),
        .done     (mac_done)
    );

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cy_reg           <= '0;
            cx_reg           <= '0;
            ky_reg           <= '0;
            kx_reg           <= '0;
            hold_reg         <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise the output on a new result, drop it once taken
            result_valid_reg <= out_load || (result_valid_reg && result_stall);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take_item)
                    begin
                        if (starts_read)
                        begin
                            cy_reg    <= CTR_W'(item.row) * CTR_W'(down_reg);
                            cx_reg    <= CTR_W'(item.col) * CTR_W'(down_reg);
                            ky_reg    <= '0;
                            kx_reg    <= '0;
                            state_reg <= ST_RUN;
                        end
                        else if (slot_free)
                        begin
                            result_reg <= imm_res;
                        end
                        else
                        begin
                            hold_reg  <= imm_res;
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_RUN:
                begin
                    // Advance across the row, then down
                    if (kx_end)
                    begin
                        kx_reg <= '0;
                        ky_reg <= ky_reg + K_W'(1);
                    end
                    else
                    begin
                        kx_reg <= kx_reg + K_W'(1);
                    end
                    if (win_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (mac_done)
                    begin
                        hold_reg.filtered <= mac_filtered;
                        hold_reg.status   <= STAT_OK;
                        state_reg         <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (slot_free)
                    begin
                        result_reg <= hold_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

`ifndef ASSERT_OFF
    // The window sum completes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ST_DRAIN)
    else $error("window sum finished outside drain");

    // The store never writes and reads in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
    else $error("image store write and read overlap");

    // Window counters stay inside the kernel
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> (3'(ky_reg) <= span) && (3'(kx_reg) <= span))
    else $error("window counter beyond kernel span");

    // An accepted in-range read starts the window walk
    assert property (@(posedge clk) disable iff (!rst_n)
        take_item && starts_read |=> state_reg == ST_RUN && ky_reg == '0 && kx_reg == '0)
    else $error("read did not start the window walk");
`endif

endmodule
